// ----- rtl/grid_strip_index_generator_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the grid strip index generator
// Clocked, reset-qualified helpers for concurrent checks.
// ---------------------------------------------------------------------------
`ifndef GRID_STRIP_INDEX_GENERATOR_UNIT_ASSERT_SVH
`define GRID_STRIP_INDEX_GENERATOR_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define GSIG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define GSIG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gsig_pkg.sv -----
// ---------------------------------------------------------------------------
// gsig_pkg
// Widths, limits and the stage record for the grid strip index generator.
// ---------------------------------------------------------------------------
package gsig_pkg;

    localparam int CELLS_W = 12;
    localparam int COL_W   = 13;
    localparam int IDX_W   = 24;

    localparam logic [CELLS_W-1:0] MAX_CELLS   = 12'd4095;
    localparam logic [CELLS_W-1:0] RESET_CELLS = 12'd1000;

    typedef struct packed {
        logic [COL_W-1:0]   vrow;
        logic [COL_W-1:0]   column;
        logic [CELLS_W-1:0] cells;
        logic               bridge;
        logic               last;
    } t_walk_item;

endpackage

// ----- rtl/gsig_stream_if.sv -----
// ---------------------------------------------------------------------------
// gsig stream interfaces
// Request and index channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface gsig_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface gsig_idx_if;
    logic        valid;
    logic        ready;
    logic [23:0] vertex_index;
    logic        bridge;
    logic        last;

    modport source (output valid, output vertex_index, output bridge, output last, input ready);
    modport sink   (input valid, input vertex_index, input bridge, input last, output ready);
endinterface

// ----- rtl/gsig_walk.sv -----
// ---------------------------------------------------------------------------
// gsig_walk
// Serpentine walk state, cell count register and the first stage register.
// ---------------------------------------------------------------------------
`include "grid_strip_index_generator_unit_assert.svh"

module gsig_walk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gsig_pkg::CELLS_W-1:0]   i_cfg_data,
    gsig_req_if.sink                       i_req,
    input  logic                           i_stage_ready,
    output logic                           o_stage_valid,
    output gsig_pkg::t_walk_item           o_item
);
    import gsig_pkg::*;

    logic [CELLS_W-1:0] r_cfg;
    logic [CELLS_W-1:0] r_row_pair;
    logic [COL_W-1:0]   r_column;
    logic               r_going_left;
    logic               r_lower_half;
    logic               r_bridge_pending;
    logic               r_valid;
    t_walk_item         r_item;

    logic [CELLS_W-1:0] n_row_pair;
    logic [COL_W-1:0]   n_column;
    logic               n_going_left;
    logic               n_lower_half;
    logic               n_bridge_pending;
    t_walk_item         n_item;

    logic [CELLS_W-1:0] cells;
    logic [COL_W-1:0]   cells_ext;
    logic [COL_W-1:0]   row_inc;
    logic               accept;
    logic               wipe;

    always_comb begin
        if (r_cfg == '0) begin
            cells = {{(CELLS_W-1){1'b0}}, 1'b1};
        end else if (r_cfg > MAX_CELLS) begin
            cells = MAX_CELLS;
        end else begin
            cells = r_cfg;
        end
    end

    assign cells_ext   = {1'b0, cells};
    assign row_inc     = {1'b0, r_row_pair} + {{(COL_W-1){1'b0}}, 1'b1};
    assign i_req.ready = !r_valid || i_stage_ready;
    assign accept      = i_req.valid && i_req.ready;
    assign wipe        = i_req.restart || (r_row_pair >= cells) || (r_column > cells_ext) ||
                         (r_bridge_pending && (row_inc >= cells_ext));

    always_comb begin
        logic [CELLS_W-1:0] e_row;
        logic [COL_W-1:0]   e_col;
        logic               e_gl;
        logic               e_lh;
        logic               e_bp;
        logic [COL_W-1:0]   e_row_inc;
        logic [COL_W-1:0]   end_col;

        e_row     = wipe ? '0 : r_row_pair;
        e_col     = wipe ? '0 : r_column;
        e_gl      = wipe ? 1'b0 : r_going_left;
        e_lh      = wipe ? 1'b0 : r_lower_half;
        e_bp      = wipe ? 1'b0 : r_bridge_pending;
        e_row_inc = {1'b0, e_row} + {{(COL_W-1){1'b0}}, 1'b1};
        end_col   = e_gl ? '0 : cells_ext;

        n_row_pair       = e_row;
        n_column         = e_col;
        n_going_left     = e_gl;
        n_lower_half     = e_lh;
        n_bridge_pending = e_bp;

        n_item.column = e_col;
        n_item.cells  = cells;
        n_item.bridge = 1'b0;
        n_item.last   = 1'b0;
        n_item.vrow   = {1'b0, e_row} + {{(COL_W-1){1'b0}}, e_lh};

        if (e_bp) begin
            n_item.vrow      = e_row_inc;
            n_item.bridge    = 1'b1;
            n_row_pair       = e_row_inc[CELLS_W-1:0];
            n_going_left     = !e_gl;
            n_lower_half     = 1'b0;
            n_bridge_pending = 1'b0;
        end else if (!e_lh) begin
            n_lower_half = 1'b1;
        end else begin
            n_lower_half = 1'b0;
            if (e_col == end_col) begin
                if (e_row_inc < cells_ext) begin
                    n_bridge_pending = 1'b1;
                end else begin
                    n_item.last  = 1'b1;
                    n_row_pair   = '0;
                    n_column     = '0;
                    n_going_left = 1'b0;
                end
            end else if (e_gl) begin
                n_column = e_col - {{(COL_W-1){1'b0}}, 1'b1};
            end else begin
                n_column = e_col + {{(COL_W-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg            <= RESET_CELLS;
            r_row_pair       <= '0;
            r_column         <= '0;
            r_going_left     <= 1'b0;
            r_lower_half     <= 1'b0;
            r_bridge_pending <= 1'b0;
        end else if (i_cfg_we) begin
            r_cfg            <= i_cfg_data;
            r_row_pair       <= '0;
            r_column         <= '0;
            r_going_left     <= 1'b0;
            r_lower_half     <= 1'b0;
            r_bridge_pending <= 1'b0;
        end else if (accept) begin
            r_row_pair       <= n_row_pair;
            r_column         <= n_column;
            r_going_left     <= n_going_left;
            r_lower_half     <= n_lower_half;
            r_bridge_pending <= n_bridge_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_stage_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_stage_valid = r_valid;
    assign o_item        = r_item;

    `GSIG_ASSERT_SAME(a_last_not_bridge, r_valid && r_item.last, !r_item.bridge,
        "last index flagged as bridge")
    `GSIG_ASSERT_SAME(a_bridge_upper, r_bridge_pending, !r_lower_half && (row_inc < cells_ext),
        "bridge pending in an inconsistent walk state")
    `GSIG_ASSERT_SAME(a_walk_in_grid, 1'b1, (r_row_pair < cells) && (r_column <= cells_ext),
        "walk position outside the grid")
    `GSIG_ASSERT_NEXT(a_stage_hold, r_valid && !i_stage_ready, r_valid && $stable(r_item),
        "stalled stage lost its transaction")
endmodule

// ----- rtl/gsig_index.sv -----
// ---------------------------------------------------------------------------
// gsig_index
// Vertex number arithmetic and the result register.
// ---------------------------------------------------------------------------
module gsig_index (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_stage_valid,
    input  gsig_pkg::t_walk_item i_item,
    output logic                 o_stage_ready,
    gsig_idx_if.source           o_idx
);
    import gsig_pkg::*;

    localparam int PROD_W = 2 * COL_W;

    logic              r_valid;
    logic [IDX_W-1:0]  r_vertex_index;
    logic              r_bridge;
    logic              r_last;

    logic [COL_W-1:0]  stride;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] n_vertex;
    logic              load;

    assign stride        = {1'b0, i_item.cells} + {{(COL_W-1){1'b0}}, 1'b1};
    assign prod          = i_item.vrow * stride;
    assign n_vertex      = prod + {{(PROD_W-COL_W){1'b0}}, i_item.column};
    assign o_stage_ready = !r_valid || o_idx.ready;
    assign load          = i_stage_valid && o_stage_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_idx.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_vertex_index <= n_vertex[IDX_W-1:0];
            r_bridge       <= i_item.bridge;
            r_last         <= i_item.last;
        end
    end

    assign o_idx.valid        = r_valid;
    assign o_idx.vertex_index = r_vertex_index;
    assign o_idx.bridge       = r_bridge;
    assign o_idx.last         = r_last;
endmodule

// ----- rtl/grid_strip_index_generator_unit.sv -----
// ---------------------------------------------------------------------------
// grid_strip_index_generator_unit
// Pipeline: two register stages, the walk item register then the index result register.
// Throughput: one index per cycle while the index channel is ready, set by the walk update in one stage.
// Reset: synchronous active-low; cell count returns to 1000, walk to start.
// A cell count write also restarts the walk.
// ---------------------------------------------------------------------------
module grid_strip_index_generator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gsig_pkg::CELLS_W-1:0] i_cfg_data,
    gsig_req_if.sink                     i_req,
    gsig_idx_if.source                   o_idx
);
    import gsig_pkg::*;

    logic       stage_valid;
    logic       stage_ready;
    t_walk_item stage_item;

    gsig_walk u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_req         (i_req),
        .i_stage_ready (stage_ready),
        .o_stage_valid (stage_valid),
        .o_item        (stage_item)
    );

    gsig_index u_index (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stage_valid (stage_valid),
        .i_item        (stage_item),
        .o_stage_ready (stage_ready),
        .o_idx         (o_idx)
    );
endmodule

// ----- sim/tb_grid_strip_index_generator_unit.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_grid_strip_index_generator_unit
// Self-checking bench for the serpentine strip index generator. A directed
// table covers reset, the cell-count extremes and restart. Random phases
// then follow, each with a fresh cell count, random restarts and random
// stalls on both channels. One long output hold-off backs up the request
// channel. Each index transaction is checked against an in-bench walk
// predictor, or against the table entry on typed directed rows.
// ---------------------------------------------------------------------------
module tb_grid_strip_index_generator_unit;

    import gsig_pkg::*;

    localparam int RAND_ITEMS  = 1900;
    localparam int DIR_ROWS    = 28;
    localparam int HOLD_CYCLES = 300;
    localparam int WDOG_LIMIT  = 3000;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic             bridge;
        logic             last;
    } t_strip_idx;

    typedef struct packed {
        t_row_kind          kind;
        logic [CELLS_W-1:0] cfg_val;
        logic               restart;
        logic               typed;
        t_strip_idx         want;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CELLS_W-1:0] i_cfg_data;

    gsig_req_if req_if ();
    gsig_idx_if idx_if ();

    grid_strip_index_generator_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_idx      (idx_if)
    );

    // walk predictor state
    logic [CELLS_W-1:0] cells_reg;
    logic [CELLS_W-1:0] cur_row;
    logic [COL_W-1:0]   cur_col;
    logic               walk_left;
    logic               walk_lower;
    logic               bridge_due;

    t_strip_idx strip_idx_q[$];
    t_strip_idx got_idx;
    t_strip_idx want_idx;
    t_dir_row   dir_rows [DIR_ROWS];

    int  errors;
    int  reqs_sent;
    int  results_seen;
    int  strips_done;
    int  bridges_seen;
    int  cfg_writes;
    int  idle_cycles;
    int  stall_left;
    int  holds_done;
    bit  no_idle;
    bit  hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_walk();
        cur_row    = '0;
        cur_col    = '0;
        walk_left  = 1'b0;
        walk_lower = 1'b0;
        bridge_due = 1'b0;
    endfunction

    function automatic t_strip_idx next_strip_index(input logic rs);
        int unsigned n;
        int unsigned vrow;
        t_strip_idx  res;
        n = (cells_reg == 0) ? 1 : cells_reg;
        if (n > MAX_CELLS) n = MAX_CELLS;
        res = '0;
        if (rs || cur_row >= n || cur_col > n || (bridge_due && cur_row + 1 >= n))
            clear_walk();
        if (bridge_due) begin
            res.vertex_index = IDX_W'((cur_row + 1) * (n + 1) + cur_col);
            res.bridge       = 1'b1;
            cur_row          = cur_row + 1'b1;
            walk_left        = !walk_left;
            walk_lower       = 1'b0;
            bridge_due       = 1'b0;
        end else begin
            vrow             = cur_row + (walk_lower ? 1 : 0);
            res.vertex_index = IDX_W'(vrow * (n + 1) + cur_col);
            if (!walk_lower) begin
                walk_lower = 1'b1;
            end else begin
                walk_lower = 1'b0;
                if (cur_col == (walk_left ? 0 : n)) begin
                    if (cur_row + 1 < n) begin
                        bridge_due = 1'b1;
                    end else begin
                        res.last = 1'b1;
                        clear_walk();
                    end
                end else if (walk_left) begin
                    cur_col = cur_col - 1'b1;
                end else begin
                    cur_col = cur_col + 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ERROR: %s", $time, msg);
    endtask

    // one request transaction; typed rows override the predicted index
    task automatic push_request(input logic rs, input logic typed, input t_strip_idx want);
        t_strip_idx pred;
        req_if.valid   <= 1'b1;
        req_if.restart <= rs;
        do @(posedge i_clk); while (!req_if.ready);
        pred = next_strip_index(rs);
        strip_idx_q.push_back(typed ? want : pred);
        reqs_sent++;
        if (!no_idle && $urandom_range(0, 9) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic write_cells(input logic [CELLS_W-1:0] val);
        req_if.valid <= 1'b0;
        while (strip_idx_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        cells_reg = val;
        clear_walk();
        cfg_writes++;
        i_cfg_we <= 1'b0;
    endtask

    // index channel sink with random stalls and one long hold-off
    initial begin
        idx_if.ready <= 1'b0;
        stall_left   = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                idx_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end else if (no_idle) begin
                idx_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                idx_if.ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 11) == 0) begin
                idx_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end else begin
                idx_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && idx_if.valid && idx_if.ready) begin
            got_idx = '{idx_if.vertex_index, idx_if.bridge, idx_if.last};
            if (strip_idx_q.size() == 0) begin
                report_mismatch($sformatf("index %0d with nothing pending", got_idx.vertex_index));
            end else begin
                want_idx = strip_idx_q.pop_front();
                if (got_idx.vertex_index !== want_idx.vertex_index)
                    report_mismatch($sformatf("vertex_index %0d, want %0d",
                        got_idx.vertex_index, want_idx.vertex_index));
                if (got_idx.bridge !== want_idx.bridge)
                    report_mismatch($sformatf("bridge %b, want %b (index %0d)",
                        got_idx.bridge, want_idx.bridge, want_idx.vertex_index));
                if (got_idx.last !== want_idx.last)
                    report_mismatch($sformatf("last %b, want %b (index %0d)",
                        got_idx.last, want_idx.last, want_idx.vertex_index));
                results_seen++;
                if (want_idx.last) strips_done++;
                if (want_idx.bridge) bridges_seen++;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (idx_if.valid && idx_if.ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WDOG_LIMIT) begin
            $display("%0t ERROR: no transaction for %0d cycles", $time, WDOG_LIMIT);
            $display("grid_strip_index_generator_unit: mismatch");
            $finish;
        end
    end

    initial begin
        logic [CELLS_W-1:0] cells_pick;
        int                 phase_len;
        int                 phase_no;
        int                 total;
        int unsigned        pick;

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_data     <= '0;
        req_if.valid   <= 1'b0;
        req_if.restart <= 1'b0;
        errors       = 0;
        reqs_sent    = 0;
        results_seen = 0;
        strips_done  = 0;
        bridges_seen = 0;
        cfg_writes   = 0;
        idle_cycles  = 0;
        holds_done   = 0;
        no_idle      = 1'b0;
        hold_req     = 1'b0;
        phase_no     = 0;

        dir_rows = '{
            '{ROW_REQ, 12'd0,    1'b0, 1'b1, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b1, '{24'd1001, 1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b1, '{24'd1,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b1, 1'b1, '{24'd0,    1'b0, 1'b0}},
            '{ROW_CFG, 12'd4095, 1'b0, 1'b0, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b1, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b1, '{24'd4096, 1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b0, '{24'd0,    1'b0, 1'b0}},
            '{ROW_CFG, 12'd1,    1'b0, 1'b0, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b1, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b1, '{24'd2,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b1, '{24'd1,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b1, '{24'd3,    1'b0, 1'b1}},
            '{ROW_CFG, 12'd0,    1'b0, 1'b0, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b1, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b1, 1'b1, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b1, '{24'd2,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b1, '{24'd1,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b1, '{24'd3,    1'b0, 1'b1}},
            '{ROW_CFG, 12'd2,    1'b0, 1'b0, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b0, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b0, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b0, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b0, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b0, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b0, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b0, '{24'd0,    1'b0, 1'b0}},
            '{ROW_REQ, 12'd0,    1'b0, 1'b0, '{24'd0,    1'b0, 1'b0}}
        };

        cells_reg = RESET_CELLS;
        clear_walk();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            if (dir_rows[k].kind == ROW_CFG)
                write_cells(dir_rows[k].cfg_val);
            else
                push_request(dir_rows[k].restart, dir_rows[k].typed, dir_rows[k].want);
        end

        // random phases, mostly small grids so strips complete often
        total = reqs_sent + RAND_ITEMS;
        while (reqs_sent < total) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                cells_pick = CELLS_W'($urandom_range(1, 6));
            else if (pick < 90)
                cells_pick = CELLS_W'($urandom_range(7, 24));
            else if (pick < 95)
                cells_pick = '0;
            else
                cells_pick = MAX_CELLS;
            write_cells(cells_pick);
            phase_no++;
            phase_len = (cells_pick == MAX_CELLS) ? 40 : $urandom_range(30, 200);
            if (phase_no == 3) hold_req = 1'b1;
            for (int i = 0; i < phase_len && reqs_sent < total; i++) begin
                no_idle = (reqs_sent > total - RAND_ITEMS / 7);
                push_request($urandom_range(0, 29) == 0, 1'b0, '0);
            end
        end

        req_if.valid <= 1'b0;
        while (strip_idx_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (strip_idx_q.size() != 0)
            report_mismatch($sformatf("%0d indices never arrived", strip_idx_q.size()));

        $display("run: %0d requests, %0d indices checked over %0d cell-count writes",
            reqs_sent, results_seen, cfg_writes);
        $display("run: %0d full strips, %0d bridge indices, %0d long output hold-offs",
            strips_done, bridges_seen, holds_done);
        if (errors == 0) begin
            $display("grid_strip_index_generator_unit: match");
        end else begin
            $display("grid_strip_index_generator_unit: mismatch");
        end
        $finish;
    end

endmodule
